// File: rtl/core/brightness_scaled_rgb_pixel_assert.svh
// Assertion macros used by the checker file of the pixel block.
// No dependencies; include by bare file name.
`ifndef BRIGHTNESS_SCALED_RGB_PIXEL_ASSERT_SVH
`define BRIGHTNESS_SCALED_RGB_PIXEL_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BSRGB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define BSRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/bsrgb_pkg.sv
// Package of the brightness-scaled pixel block: word types, stage enables,
// register indexes and default fraction width. No dependencies.
package bsrgb_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_COLOR_LEVELS = 2'd0,
		REG_Y_MIN        = 2'd1,
		REG_Y_SCALE      = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [19:0] red_frac;
		logic signed [19:0] green_frac;
		logic signed [19:0] blue_frac;
		logic signed [31:0] luminance;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} pixel_out_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

endpackage

// File: rtl/core/bsrgb_chan.sv
// One colour channel of the pixel pipeline: level product, clamp, delay,
// brightness product. Depends on bsrgb_pkg for the stage enable struct and default fraction width.
module bsrgb_chan #(
	parameter int FRAC_BITS = bsrgb_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  bsrgb_pkg::pipe_en_t  en,
	input  logic signed [19:0]   frac,
	input  logic [7:0]           levels,
	input  logic [FRAC_BITS:0]   bright_s3,
	output logic [7:0]           level_out_s4
);

	logic signed [28:0]          prod_s1;
	logic signed [28:0]          quot;
	logic [7:0]                  level_c;
	logic [7:0]                  level_s2;
	logic [7:0]                  level_s3;
	logic [FRAC_BITS+8:0]        scaled;

	always_comb begin
		quot = prod_s1 >>> FRAC_BITS;
		if (prod_s1 <= 29'sd0) begin
			level_c = 8'd0;
		end else if (quot > $signed({21'd0, levels})) begin
			level_c = levels;
		end else begin
			level_c = quot[7:0];
		end
	end

	assign scaled = {8'd0, bright_s3} * {{(FRAC_BITS+1){1'b0}}, level_s3};

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1 <= $signed({1'b0, levels}) * frac;
		end
		if (en.s2) begin
			level_s2 <= level_c;
		end
		if (en.s3) begin
			level_s3 <= level_s2;
		end
		if (en.s4) begin
			level_out_s4 <= scaled[FRAC_BITS+7:FRAC_BITS];
		end
	end

endmodule

// File: rtl/core/brightness_scaled_rgb_pixel.sv
// Top level of the brightness-scaled pixel block: configuration registers,
// luminance path, stage valids. Depends on bsrgb_pkg and bsrgb_chan.
//
// Pixels enter on in_valid/in_ready as one pixel_in_t word and leave on
// out_valid/out_ready as one pixel_out_t word, one result word per pixel,
// in order. Alpha is always opaque and not carried.
// Four register stages: level products and luminance difference, level
// clamp and luminance times scale, brightness clamp, brightness times level
// into the output register. A word moves through the stage registers s1 to s4
// in order and out_valid follows valid_s4; one pixel is taken every
// cycle while the receiver keeps up.
// The 33 by 24 bit luminance product sets the depth of the second stage.
// When out_ready is low the stages fill up and hold; in_ready falls only
// once every stage holds a word, so nothing is lost or repeated.
// Registers are written through cfg_we/cfg_index/cfg_data, with no wait;
// write them only while the pipeline is empty. Index 3 is ignored.
// Reset empties the pipeline and loads color_levels 255, y_min 0 and
// y_scale 65536.
module brightness_scaled_rgb_pixel #(
	parameter int FRAC_BITS = bsrgb_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bsrgb_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [bsrgb_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bsrgb_pkg::pixel_in_t                in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bsrgb_pkg::pixel_out_t               out_data
);

	localparam logic signed [56:0] P_ONE = 57'sd1 <<< (2 * FRAC_BITS);
	localparam logic [FRAC_BITS:0] B_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	logic [7:0]              color_levels_q;
	logic signed [31:0]      y_min_q;
	logic signed [23:0]      y_scale_q;

	bsrgb_pkg::pipe_en_t     en;
	logic                    valid_s1;
	logic                    valid_s2;
	logic                    valid_s3;
	logic                    valid_s4;

	logic signed [32:0]      diff_s1;
	logic signed [56:0]      p_s2;
	logic [FRAC_BITS:0]      bright_c;
	logic [FRAC_BITS:0]      bright_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_levels_q <= 8'd255;
			y_min_q        <= 32'sd0;
			y_scale_q      <= 24'sd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				bsrgb_pkg::REG_COLOR_LEVELS: color_levels_q <= cfg_data[7:0];
				bsrgb_pkg::REG_Y_MIN:        y_min_q        <= cfg_data[31:0];
				bsrgb_pkg::REG_Y_SCALE:      y_scale_q      <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		en.s4 = !valid_s4 || out_ready;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign in_ready  = en.s1;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= in_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		if (p_s2 <= 57'sd0) begin
			bright_c = '0;
		end else if (p_s2 >= P_ONE) begin
			bright_c = B_ONE;
		end else begin
			bright_c = p_s2[2*FRAC_BITS:FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			diff_s1 <= {in_data.luminance[31], in_data.luminance} - {y_min_q[31], y_min_q};
		end
		if (en.s2) begin
			p_s2 <= diff_s1 * y_scale_q;
		end
		if (en.s3) begin
			bright_s3 <= bright_c;
		end
	end

	bsrgb_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
		.clk          (clk),
		.en           (en),
		.frac         (in_data.red_frac),
		.levels       (color_levels_q),
		.bright_s3    (bright_s3),
		.level_out_s4 (out_data.red_out)
	);

	bsrgb_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
		.clk          (clk),
		.en           (en),
		.frac         (in_data.green_frac),
		.levels       (color_levels_q),
		.bright_s3    (bright_s3),
		.level_out_s4 (out_data.green_out)
	);

	bsrgb_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
		.clk          (clk),
		.en           (en),
		.frac         (in_data.blue_frac),
		.levels       (color_levels_q),
		.bright_s3    (bright_s3),
		.level_out_s4 (out_data.blue_out)
	);

endmodule

// File: rtl/core/bsrgb_checker.sv
// Port-level checker of the pixel block, bound to the top level.
// Depends on bsrgb_pkg and brightness_scaled_rgb_pixel_assert.svh.
`include "brightness_scaled_rgb_pixel_assert.svh"

module bsrgb_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input bsrgb_pkg::pixel_out_t out_data
);

	`BSRGB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result word dropped or changed while stalled")

	`BSRGB_ASSERT_NOW(a_no_back_pressure, clk, arst_n, out_ready, in_ready, "input stalled while receiver is ready")

	`BSRGB_ASSERT_NEXT(a_latency, clk, arst_n, (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid, "accepted word not delivered after four cycles")

endmodule

bind brightness_scaled_rgb_pixel bsrgb_checker u_bsrgb_checker (.*);
